FILE: rtl/core/pec_pkg.sv
// ----------------------------------------------------------------------------
// pec_pkg
// Shared types and constants of the percent escape codec: the escape state,
// one result entry, a group of up to three results and the register indexes.
// ----------------------------------------------------------------------------
package pec_pkg;

    // Configuration register indexes.
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_TOLERANT  = 1'b1;

    // Most results that one input byte can cause.
    localparam int unsigned MAX_RESULTS = 3;

    // Escape phase codes.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PERCENT = 2'd1;
    localparam logic [1:0] PH_DIGIT   = 2'd2;

    // Characters that the codec treats specially.
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOT      = 8'h2e;
    localparam logic [7:0] CH_COMMA    = 8'h2c;
    localparam logic [7:0] CH_STAR     = 8'h2a;
    localparam logic [7:0] CH_QUESTION = 8'h3f;

    // Escape state carried from byte to byte.
    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] held_digit;
        logic       dropping;
    } state_t;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } entry_t;

    // The results caused by one input byte; entry 0 goes out first.
    typedef struct packed {
        entry_t [MAX_RESULTS-1:0] item;
        logic [1:0]               count;
    } group_t;

endpackage

FILE: rtl/core/percent_escape_codec.sv
// ----------------------------------------------------------------------------
// percent_escape_codec
// Streaming percent encoder and decoder, one string byte per input transfer.
// ----------------------------------------------------------------------------
//  channel   direction  transfer contents
//  s_axis    in         tdata = in_byte [7:0], tlast = in_last
//  m_axis    out        tdata = out_byte [7:0], tlast = out_last,
//                       tuser = bad_escape [0]
//  cfg       in         cfg_addr 0 = direction, 1 = tolerant
//
//  A byte is converted in the cycle it is accepted and its results are
//  registered; the first result is offered in the next cycle.
//  Each byte causes up to three results, or none; the output stream moves
//  one result per cycle while m_tready is high.
//  Reset clears the escape state and both registers and empties the
//  result register.
//  s_tready is low while more than one result is pending, or while the
//  last pending result is held by a stalled output.
// ----------------------------------------------------------------------------
module percent_escape_codec
(
    input  logic       clk,
    input  logic       rst_n,
    // Input stream.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,
    // Output stream.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,
    output logic [0:0] m_tuser,    // [0] bad_escape
    // Configuration write port.
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic       cfg_wdata
);

    logic            direction_reg;
    logic            tolerant_reg;
    pec_pkg::state_t state_reg;
    pec_pkg::state_t state_next;
    pec_pkg::group_t grp;
    pec_pkg::entry_t head;
    logic            in_xfer;

    assign in_xfer = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            tolerant_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pec_pkg::REG_DIRECTION: direction_reg <= cfg_wdata;
                pec_pkg::REG_TOLERANT:  tolerant_reg  <= cfg_wdata;
                default:                direction_reg <= direction_reg;
            endcase
        end
    end

    // Conversion of the incoming byte.
    pec_step u_step
    (
        .direction (direction_reg),
        .tolerant  (tolerant_reg),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cur       (state_reg),
        .nxt       (state_next),
        .grp       (grp)
    );

    // Escape state advances on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Result register and output sequencing.
    pec_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_xfer),
        .grp        (grp),
        .load_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .head       (head)
    );

    assign m_tdata    = head.data;
    assign m_tlast    = head.last;
    assign m_tuser[0] = head.bad;

    // The escape phase never reaches the unused code.
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != 2'd3))
        else $error("percent_escape_codec: illegal escape phase");

    // Encoding leaves no escape state behind.
    a_encode_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !direction_reg) |=> (state_reg == '0))
        else $error("percent_escape_codec: state left after encoding");

    // A byte with the end mark leaves no escape pending.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tlast) |=> (state_reg.phase == pec_pkg::PH_IDLE) && !state_reg.dropping)
        else $error("percent_escape_codec: escape pending after end of string");

endmodule

FILE: rtl/core/pec_step.sv
// ----------------------------------------------------------------------------
// pec_step
// Combinational conversion of one input byte: from the byte, the end mark,
// the mode and the escape state it forms the result group and the next state.
// ----------------------------------------------------------------------------
module pec_step
(
    input  logic            direction,
    input  logic            tolerant,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  pec_pkg::state_t cur,
    output pec_pkg::state_t nxt,
    output pec_pkg::group_t grp
);

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= 8'h41) && (b <= 8'h5a);
    endfunction

    function automatic logic is_lower(input logic [7:0] b);
        return (b >= 8'h61) && (b <= 8'h7a);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || ((b >= 8'h41) && (b <= 8'h46)) || ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    // Value of a hex digit character; zero for anything else.
    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (is_digit(b))
        begin
            v = b - 8'h30;
        end
        else if ((b >= 8'h61) && (b <= 8'h66))
        begin
            v = b - 8'h57;
        end
        else if ((b >= 8'h41) && (b <= 8'h46))
        begin
            v = b - 8'h37;
        end
        return v[3:0];
    endfunction

    // Upper-case hex character of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        c = {4'd0, nib} + 8'h30;
        if (nib > 4'd9)
        begin
            c = c + 8'd7;
        end
        return c;
    endfunction

    logic [7:0] ob [3];
    logic [1:0] n;
    logic       err;
    logic       alnum;
    logic       tol_set;

    always_comb
    begin
        ob[0]   = 8'd0;
        ob[1]   = 8'd0;
        ob[2]   = 8'd0;
        n       = 2'd0;
        err     = 1'b0;
        nxt     = cur;
        alnum   = is_digit(in_byte) || is_upper(in_byte) || is_lower(in_byte);
        tol_set = (in_byte == pec_pkg::CH_SPACE) || (in_byte == pec_pkg::CH_DOT)
               || (in_byte == pec_pkg::CH_COMMA) || (in_byte == pec_pkg::CH_STAR)
               || (in_byte == pec_pkg::CH_QUESTION);

        if (!direction)
        begin
            // Encoding: pass the allowed set, escape everything else.
            nxt = '0;
            if (alnum || (tolerant && tol_set))
            begin
                ob[0] = in_byte;
                n     = 2'd1;
            end
            else
            begin
                ob[0] = pec_pkg::CH_PERCENT;
                ob[1] = hex_char(in_byte[7:4]);
                ob[2] = hex_char(in_byte[3:0]);
                n     = 2'd3;
            end
        end
        else if (tolerant)
        begin
            // Lenient decoding: broken escapes come out literally.
            nxt.dropping = 1'b0;
            if (cur.phase == pec_pkg::PH_IDLE)
            begin
                if ((in_byte == pec_pkg::CH_PERCENT) && !in_last)
                begin
                    nxt.phase = pec_pkg::PH_PERCENT;
                end
                else
                begin
                    ob[0] = in_byte;
                    n     = 2'd1;
                end
            end
            else if (cur.phase == pec_pkg::PH_PERCENT)
            begin
                if (is_hex(in_byte) && !in_last)
                begin
                    nxt.held_digit = in_byte;
                    nxt.phase      = pec_pkg::PH_DIGIT;
                end
                else
                begin
                    nxt.phase = pec_pkg::PH_IDLE;
                    ob[0]     = pec_pkg::CH_PERCENT;
                    n         = 2'd1;
                    if (is_hex(in_byte))
                    begin
                        ob[1] = in_byte;
                        n     = 2'd2;
                    end
                    else if ((in_byte == pec_pkg::CH_PERCENT) && !in_last)
                    begin
                        nxt.phase = pec_pkg::PH_PERCENT;
                    end
                    else
                    begin
                        ob[1] = in_byte;
                        n     = 2'd2;
                    end
                end
            end
            else
            begin
                nxt.phase      = pec_pkg::PH_IDLE;
                nxt.held_digit = 8'd0;
                if (is_hex(in_byte))
                begin
                    ob[0] = {hex_value(cur.held_digit), hex_value(in_byte)};
                    n     = 2'd1;
                end
                else
                begin
                    ob[0] = pec_pkg::CH_PERCENT;
                    ob[1] = cur.held_digit;
                    n     = 2'd2;
                    if ((in_byte == pec_pkg::CH_PERCENT) && !in_last)
                    begin
                        nxt.phase = pec_pkg::PH_PERCENT;
                    end
                    else
                    begin
                        ob[2] = in_byte;
                        n     = 2'd3;
                    end
                end
            end
        end
        else if (!cur.dropping)
        begin
            // Strict decoding: anything unexpected is an error.
            if (cur.phase == pec_pkg::PH_IDLE)
            begin
                if (alnum)
                begin
                    ob[0] = in_byte;
                    n     = 2'd1;
                end
                else if ((in_byte == pec_pkg::CH_PERCENT) && !in_last)
                begin
                    nxt.phase = pec_pkg::PH_PERCENT;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            else if (cur.phase == pec_pkg::PH_PERCENT)
            begin
                if (is_hex(in_byte) && !in_last)
                begin
                    nxt.held_digit = in_byte;
                    nxt.phase      = pec_pkg::PH_DIGIT;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            else
            begin
                if (is_hex(in_byte))
                begin
                    ob[0]          = {hex_value(cur.held_digit), hex_value(in_byte)};
                    n              = 2'd1;
                    nxt.phase      = pec_pkg::PH_IDLE;
                    nxt.held_digit = 8'd0;
                end
                else
                begin
                    err = 1'b1;
                end
            end
        end

        // The end of a string clears the escape state.
        if (in_last)
        begin
            nxt = '0;
        end

        // Assemble the result group.
        for (int k = 0; k < pec_pkg::MAX_RESULTS; k++)
        begin
            grp.item[k].data = ob[k];
            grp.item[k].last = in_last && (n == 2'(k + 1));
            grp.item[k].bad  = 1'b0;
        end
        grp.count = n;

        // An error gives a single flagged result and drops to the end.
        if (err)
        begin
            nxt                   = '0;
            nxt.dropping          = !in_last;
            grp.item[0].data      = 8'd0;
            grp.item[0].last      = 1'b1;
            grp.item[0].bad       = 1'b1;
            grp.count             = 2'd1;
        end
    end

endmodule

FILE: rtl/core/pec_emit.sv
// ----------------------------------------------------------------------------
// pec_emit
// Result register: holds the group of one input byte and hands its entries
// to the output channel one transfer per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module pec_emit
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  pec_pkg::group_t grp,
    output logic            load_ready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output pec_pkg::entry_t head
);

    pec_pkg::entry_t [pec_pkg::MAX_RESULTS-1:0] item_reg;
    logic [1:0]                                 count_reg;
    logic                                       out_xfer;

    assign m_tvalid   = (count_reg != 2'd0);
    assign out_xfer   = m_tvalid && m_tready;
    assign head       = item_reg[0];
    // A new group fits once the last pending entry leaves.
    assign load_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= grp.count;
        end
        else if (out_xfer)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // Entries shift toward the head as they leave.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= grp.item;
        end
        else if (out_xfer)
        begin
            item_reg[0] <= item_reg[1];
            item_reg[1] <= item_reg[2];
        end
    end

    // No new group may be taken while two or more entries still wait.
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg > 2'd1) |-> !load_ready)
        else $error("pec_emit: ready with several entries pending");

    // An error result always ends its string.
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && head.bad) |-> head.last)
        else $error("pec_emit: error result without end mark");

    // A held entry that is not taken stays on the output.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && !load) |=> m_tvalid)
        else $error("pec_emit: pending result lost");

endmodule

FILE: bench/pec_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// pec_scoreboard_pkg
// Scoreboard for the percent escape codec. It keeps its own copy of the escape
// state and both registers, works out the results of every byte that the
// block accepts, and compares each output transfer with the oldest of them.
// ----------------------------------------------------------------------------
package pec_scoreboard_pkg;

    import pec_pkg::*;

    class escape_scoreboard;

        logic        decoding;
        logic        lenient;
        state_t      st;
        entry_t      expected_out[$];
        logic [7:0]  converted[$];
        int unsigned error_count;

        function new();
            decoding    = 1'b0;
            lenient     = 1'b0;
            st          = '0;
            error_count = 0;
        endfunction

        // Mirror a write to one of the two registers.
        function void write_reg(logic idx, logic value);
            if (idx == REG_DIRECTION)
                decoding = value;
            else
                lenient = value;
        endfunction

        function bit is_alnum(logic [7:0] b);
            return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9");
        endfunction

        function bit is_hex(logic [7:0] b);
            return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
        endfunction

        function logic [3:0] hex_value(logic [7:0] b);
            if (b >= "0" && b <= "9")
                return 4'(b - "0");
            if (b >= "a" && b <= "f")
                return 4'(b - "a" + 10);
            return 4'(b - "A" + 10);
        endfunction

        // Upper-case hex digit of one nibble.
        function logic [7:0] hex_char(logic [3:0] nib);
            return (nib > 4'd9) ? 8'h37 + 8'(nib) : 8'h30 + 8'(nib);
        endfunction

        // Lenient decoding of a byte with no escape open.
        function void fresh_byte(logic [7:0] b, logic last);
            if (b == CH_PERCENT && !last)
                st.phase = PH_PERCENT;
            else
                converted.push_back(b);
        endfunction

        // Work out the results of one accepted byte. Returns 0 when the byte
        // was dropped because strict decoding is skipping to the end of the
        // string.
        function bit note_byte(logic [7:0] b, logic last);
            entry_t e;
            bit     err;
            err = 1'b0;
            converted.delete();
            if (!decoding) begin
                // Encoding keeps no state from byte to byte.
                st = '0;
                if (is_alnum(b) || (lenient && (b == CH_SPACE || b == CH_DOT || b == CH_COMMA
                                                || b == CH_STAR || b == CH_QUESTION))) begin
                    converted.push_back(b);
                end
                else begin
                    converted.push_back(CH_PERCENT);
                    converted.push_back(hex_char(b[7:4]));
                    converted.push_back(hex_char(b[3:0]));
                end
            end
            else if (lenient) begin
                // Lenient decoding: a broken escape comes out literally.
                st.dropping = 1'b0;
                case (st.phase)
                    PH_IDLE: fresh_byte(b, last);
                    PH_PERCENT:
                    begin
                        if (is_hex(b) && !last) begin
                            st.held_digit = b;
                            st.phase      = PH_DIGIT;
                        end
                        else begin
                            st.phase = PH_IDLE;
                            converted.push_back(CH_PERCENT);
                            if (is_hex(b))
                                converted.push_back(b);
                            else
                                fresh_byte(b, last);
                        end
                    end
                    default:
                    begin
                        st.phase = PH_IDLE;
                        if (is_hex(b)) begin
                            converted.push_back({hex_value(st.held_digit), hex_value(b)});
                        end
                        else begin
                            converted.push_back(CH_PERCENT);
                            converted.push_back(st.held_digit);
                            fresh_byte(b, last);
                        end
                        st.held_digit = '0;
                    end
                endcase
            end
            else begin
                // Strict decoding: after an error, skip to the end of the string.
                if (st.dropping) begin
                    if (last)
                        st = '0;
                    return 1'b0;
                end
                case (st.phase)
                    PH_IDLE:
                    begin
                        if (is_alnum(b))
                            converted.push_back(b);
                        else if (b == CH_PERCENT && !last)
                            st.phase = PH_PERCENT;
                        else
                            err = 1'b1;
                    end
                    PH_PERCENT:
                    begin
                        if (is_hex(b) && !last) begin
                            st.held_digit = b;
                            st.phase      = PH_DIGIT;
                        end
                        else begin
                            err = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (is_hex(b)) begin
                            converted.push_back({hex_value(st.held_digit), hex_value(b)});
                            st.phase      = PH_IDLE;
                            st.held_digit = '0;
                        end
                        else begin
                            err = 1'b1;
                        end
                    end
                endcase
                if (err) begin
                    st.phase      = PH_IDLE;
                    st.held_digit = '0;
                    st.dropping   = !last;
                    e.data = '0;
                    e.last = 1'b1;
                    e.bad  = 1'b1;
                    expected_out.push_back(e);
                    return 1'b1;
                end
            end

            if (last)
                st = '0;

            // Only the final result of a terminated string carries the end mark.
            foreach (converted[k]) begin
                e.data = converted[k];
                e.last = last && (k == converted.size() - 1);
                e.bad  = 1'b0;
                expected_out.push_back(e);
            end
            return 1'b1;
        endfunction

        // Compare one output transfer with the oldest expected result.
        function void check_result(logic [7:0] data, logic last, logic bad);
            entry_t e;
            if (expected_out.size() == 0) begin
                $error("Unexpected result: out_byte %h, out_last %b, bad_escape %b",
                       data, last, bad);
                error_count++;
                return;
            end
            e = expected_out.pop_front();
            if (data !== e.data) begin
                $error("out_byte mismatch: expected %h, actual %h", e.data, data);
                error_count++;
            end
            if (last !== e.last) begin
                $error("out_last mismatch: expected %b, actual %b", e.last, last);
                error_count++;
            end
            if (bad !== e.bad) begin
                $error("bad_escape mismatch: expected %b, actual %b", e.bad, bad);
                error_count++;
            end
        endfunction

    endclass

endpackage

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the percent escape codec. A directed run covers the
// character classes, error handling and broken escapes of each mode; then
// random strings, mostly well-formed escapes with some noise, run under all
// four register settings and two random ones, with random stalls on both
// streams before the last phase; the scoreboard checks each output transfer.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pec_pkg::*;
    import pec_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned ITEM_TARGET   = 110;
    localparam int unsigned RANDOM_PHASES = 6;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = '0;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;
    logic       cfg_we    = 1'b0;
    logic       cfg_addr  = 1'b0;
    logic       cfg_wdata = 1'b0;

    escape_scoreboard codec_sb;
    bit               idle_on     = 1'b1;
    int unsigned      live_items  = 0;
    int unsigned      cycle_count = 0;
    int unsigned      stall_left  = 0;

    string hex_digits = "0123456789abcdefABCDEF";
    string alnum_set  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
    string punct_set  = " .,*?%-~/";

    percent_escape_codec dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Give up once the run is far beyond its slowest correct length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side: check each transfer and stall in short random bursts.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            codec_sb.check_result(m_tdata, m_tlast, m_tuser[0]);
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Offer one byte, with a random gap ahead of it, and wait for the transfer.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        void'(codec_sb.note_byte(b, last));
        live_items++;
    endtask

    task automatic send_text(input string text, input bit close);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], close && i == text.len() - 1);
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (codec_sb.expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on consecutive cycles; the block is idle here.
    task automatic configure(input logic decode, input logic lenient);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_DIRECTION;
        cfg_wdata <= decode;
        @(posedge clk);
        codec_sb.write_reg(REG_DIRECTION, decode);
        cfg_addr  <= REG_TOLERANT;
        cfg_wdata <= lenient;
        @(posedge clk);
        codec_sb.write_reg(REG_TOLERANT, lenient);
        cfg_we    <= 1'b0;
    endtask

    // One random string: mostly letters, digits and valid escapes, with some
    // punctuation, broken escapes and arbitrary bytes mixed in.
    task automatic send_random_string();
        logic [7:0]  text[$];
        int unsigned len;
        len = $urandom_range(1, 4);
        repeat (len)
        begin
            case ($urandom_range(0, 9))
                0: text.push_back(8'($urandom_range(0, 255)));
                1, 2, 3:
                begin
                    text.push_back(CH_PERCENT);
                    text.push_back(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
                    text.push_back(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
                end
                4:
                begin
                    text.push_back(CH_PERCENT);
                    if ($urandom_range(0, 1) == 1)
                        text.push_back(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
                end
                5: text.push_back(punct_set[$urandom_range(0, punct_set.len() - 1)]);
                default: text.push_back(alnum_set[$urandom_range(0, alnum_set.len() - 1)]);
            endcase
        end
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        int unsigned target;
        int unsigned base;
        logic        decode;
        logic        lenient;
        codec_sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Strict encoding: pass-through, zero byte, top byte, percent sign.
        configure(1'b0, 1'b0);
        send_text("Az9", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_text("%", 1'b1);

        // Tolerant encoding: the extra pass-through set.
        wait_drained();
        configure(1'b0, 1'b1);
        send_text(" .,*?~", 1'b1);

        // Strict decoding: escapes in both cases, an illegal byte followed by
        // dropped input, and incomplete escapes at the end of a string.
        wait_drained();
        configure(1'b1, 1'b0);
        send_text("%4a%4F", 1'b1);
        send_text("a-x", 1'b1);
        send_text("%", 1'b1);
        send_text("%4", 1'b1);

        // An escape begun in strict mode finishes under tolerant decoding.
        send_text("%4", 1'b0);
        wait_drained();
        configure(1'b1, 1'b1);
        send_text("1", 1'b1);

        // Tolerant decoding: stray percent reopening an escape, and the flush
        // of a pending percent and digit at the end of the string.
        send_text("%%41%4%", 1'b1);

        // Random strings under each setting, with no idling in the last phase;
        // the phases share what is left of the item budget.
        base = live_items;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            decode  = (ph < 4) ? ph[1] : 1'($urandom_range(0, 1));
            lenient = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
            wait_drained();
            if (ph == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            configure(decode, lenient);
            target = base + (ph + 1) * (ITEM_TARGET - base) / RANDOM_PHASES;
            while (live_items < target)
                send_random_string();
        end

        wait_drained();
        if (codec_sb.expected_out.size() != 0)
        begin
            $error("%0d expected results never arrived", codec_sb.expected_out.size());
            codec_sb.error_count++;
        end
        if (codec_sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/pec_pkg.sv
rtl/core/pec_step.sv
rtl/core/pec_emit.sv
rtl/core/percent_escape_codec.sv
bench/pec_scoreboard_pkg.sv
bench/tb_top.sv
